// ===== hw/rtl/hes_pkg.sv =====
// ----------------------------------------------------------------------------
// hes_pkg: shared types and constants of the hit envelope smoother
// Holds the event codes, configuration layout, reset values, the exponential
// table and the request and response types of the bit-serial multiplier.
// ----------------------------------------------------------------------------
package hes_pkg;

    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned AMOUNT_W   = 16;
    localparam int unsigned DT_W       = 16;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DECAY_W    = 12;

    localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'd32768;

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT   = 2'd0,
        CMD_DEATH = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BUMP   = 3'd0,
        CFG_HIT_GAIN   = 3'd1,
        CFG_DECAY_RATE = 3'd2,
        CFG_CHASE_RATE = 3'd3,
        CFG_SNAP_FLOOR = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        min_bump;
        logic [15:0]        hit_gain;
        logic [DECAY_W-1:0] decay_rate;
        logic [15:0]        chase_rate;
        logic [15:0]        snap_floor;
    } t_cfg;

    localparam logic [15:0]        RST_MIN_BUMP   = 16'd3932;
    localparam logic [15:0]        RST_HIT_GAIN   = 16'd1835;
    localparam logic [DECAY_W-1:0] RST_DECAY_RATE = 12'd640;
    localparam logic [15:0]        RST_CHASE_RATE = 16'd4096;
    localparam logic [15:0]        RST_SNAP_FLOOR = 16'd33;

    // Serial multiplier: multiplicand up to 25 bits, multiplier up to 20 bits,
    // one multiplier bit retired per cycle.
    localparam int unsigned MUL_A_W   = 25;
    localparam int unsigned MUL_B_W   = 20;
    localparam int unsigned MUL_CNT_W = 5;
    localparam logic [MUL_CNT_W-1:0] MUL_LEN_SHORT = 5'd16;
    localparam logic [MUL_CNT_W-1:0] MUL_LEN_LONG  = 5'd20;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
        logic [MUL_CNT_W-1:0] len;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_A_W-1:0] hi;
        logic [MUL_B_W-1:0] lo;
    } t_mul_rsp;

    // round(32768 * exp(-i/16))
    localparam logic [15:0] EXP_TAB [64] = '{
        16'd32768, 16'd30783, 16'd28918, 16'd27166, 16'd25520, 16'd23974, 16'd22521, 16'd21157,
        16'd19875, 16'd18671, 16'd17539, 16'd16477, 16'd15479, 16'd14541, 16'd13660, 16'd12832,
        16'd12055, 16'd11324, 16'd10638, 16'd9994,  16'd9388,  16'd8819,  16'd8285,  16'd7783,
        16'd7312,  16'd6869,  16'd6452,  16'd6061,  16'd5694,  16'd5349,  16'd5025,  16'd4721,
        16'd4435,  16'd4166,  16'd3914,  16'd3676,  16'd3454,  16'd3244,  16'd3048,  16'd2863,
        16'd2690,  16'd2527,  16'd2374,  16'd2230,  16'd2095,  16'd1968,  16'd1849,  16'd1737,
        16'd1631,  16'd1533,  16'd1440,  16'd1352,  16'd1271,  16'd1194,  16'd1121,  16'd1053,
        16'd990,   16'd930,   16'd873,   16'd820,   16'd771,   16'd724,   16'd680,   16'd639
    };

endpackage

// ===== hw/rtl/hes_evt_if.sv =====
// ----------------------------------------------------------------------------
// hes_evt_if: event channel
// Valid/ready channel that carries one event beat: command, amount and dt.
// ----------------------------------------------------------------------------
interface hes_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] amount;
    logic [15:0] dt;

    modport source (output valid, output cmd, output amount, output dt, input ready);
    modport sink   (input valid, input cmd, input amount, input dt, output ready);
endinterface

// ===== hw/rtl/hes_res_if.sv =====
// ----------------------------------------------------------------------------
// hes_res_if: result channel
// Valid/ready channel that carries one result beat: the smoothed level.
// ----------------------------------------------------------------------------
interface hes_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// ===== hw/rtl/hes_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hes_cfg_regs: configuration register file
// Write-only registers, loaded by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hes_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [hes_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [hes_pkg::CFG_DATA_W-1:0] i_data,
    output hes_pkg::t_cfg                 o_cfg
);
    import hes_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bump   <= RST_MIN_BUMP;
            r_cfg.hit_gain   <= RST_HIT_GAIN;
            r_cfg.decay_rate <= RST_DECAY_RATE;
            r_cfg.chase_rate <= RST_CHASE_RATE;
            r_cfg.snap_floor <= RST_SNAP_FLOOR;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_MIN_BUMP:   r_cfg.min_bump   <= i_data;
                CFG_HIT_GAIN:   r_cfg.hit_gain   <= i_data;
                CFG_DECAY_RATE: r_cfg.decay_rate <= i_data[DECAY_W-1:0];
                CFG_CHASE_RATE: r_cfg.chase_rate <= i_data;
                CFG_SNAP_FLOOR: r_cfg.snap_floor <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/hes_serial_mul.sv =====
// ----------------------------------------------------------------------------
// hes_serial_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle, LSB first; the product leaves as
// {hi, lo} with the low bits shifted into the top of lo.
// ----------------------------------------------------------------------------
module hes_serial_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hes_pkg::t_mul_req i_req,
    output hes_pkg::t_mul_rsp o_rsp
);
    import hes_pkg::*;

    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_A_W:0]     n_sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign n_sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.len;
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_hi  <= '0;
                r_lo  <= '0;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_hi   <= n_sum[MUL_A_W:1];
                r_lo   <= {n_sum[0], r_lo[MUL_B_W-1:1]};
                r_b    <= {1'b0, r_b[MUL_B_W-1:1]};
                r_done <= (r_cnt == MUL_CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

endmodule

// ===== hw/rtl/hit_envelope_smoother.sv =====
// ----------------------------------------------------------------------------
// hit_envelope_smoother: two-stage damage flash envelope, Q1.15
// Event in, smoothed level out; products are formed one bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event beat (cmd, amount, dt); o_res returns exactly one
//   beat per event with the smoothed level after that event.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data; write it
//   only while no event is in flight.
//   The block works on one event at a time. All products go through one
//   bit-serial shift-add multiplier, so the multiplier length sets latency.
//   Death, clear, zero-amount hit and zero-dt tick use no product, a hit
//   uses amount*gain, and a tick uses, in order, decay_rate*dt, slope*frac,
//   envelope*factor, chase_rate*dt and distance*alpha (16 bits each but
//   slope*frac at 20). When the decay argument reaches 4.0 the envelope
//   drops to zero and slope*frac and envelope*factor are skipped.
//   A result register sits on o_res: the next event is taken while the last
//   result still waits. If the receiver stalls, the following result is held
//   inside and i_evt stays not ready until the result register frees up.
//   Reset clears both stages, the result register, and restores config.
// ----------------------------------------------------------------------------
module hit_envelope_smoother (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hes_evt_if.sink                       i_evt,
    hes_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [hes_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hes_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hes_pkg::*;

    localparam int unsigned P_W = MUL_A_W + 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIT_MUL,
        ST_HIT_SUM,
        ST_DEC_X,
        ST_DEC_F,
        ST_DEC_E,
        ST_CHASE_A,
        ST_CHASE_S,
        ST_DONE
    } t_state;

    t_cfg     cfg;
    t_mul_rsp mul_rsp;

    t_state            r_state;
    t_mul_req          r_mreq;
    logic              r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_env;
    logic [LEVEL_W-1:0] r_sm;
    logic [DT_W-1:0]    r_dt;
    logic [15:0]        r_tab_hi;
    logic [22:0]        r_bump;
    logic               r_dir;

    // Product of a 16-step multiply: hi bits plus the 16 low bits in lo.
    logic [P_W-1:0]     p16;
    logic [27:0]        dec_x;
    logic               dec_big;
    logic [5:0]         dec_idx;
    logic [19:0]        dec_frac;
    logic [15:0]        tab_hi;
    logic [15:0]        tab_lo;
    logic [15:0]        tab_diff;
    logic [22:0]        hit_prod;
    logic [22:0]        hit_bump;
    logic [23:0]        hit_sum;
    logic [LEVEL_W-1:0] hit_env;
    logic [15:0]        factor;
    logic [LEVEL_W-1:0] env_dec;
    logic [31:0]        chase_prod;
    logic [MUL_A_W-1:0] alpha;
    logic               env_ge;
    logic [LEVEL_W-1:0] env_gap;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0] sm_next;
    logic               snap;
    logic               evt_fire;
    logic               out_free;

    hes_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    hes_serial_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_mreq),
        .o_rsp  (mul_rsp)
    );

    assign evt_fire = i_evt.valid && i_evt.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign p16      = {mul_rsp.hi, mul_rsp.lo[MUL_B_W-1 -: 16]};

    always_comb begin
        // Hit: bump = max(min_bump, amount*gain >> 9), then add and clamp to 1.0.
        hit_prod = p16[31:9];
        hit_bump = (hit_prod < {7'd0, cfg.min_bump}) ? {7'd0, cfg.min_bump} : hit_prod;
        hit_sum  = {8'd0, r_env} + {1'b0, r_bump};
        hit_env  = (hit_sum > {8'd0, ONE_Q15}) ? ONE_Q15 : hit_sum[LEVEL_W-1:0];

        // Decay argument x = decay_rate*dt, Q4.24; segment index and fraction.
        dec_x    = p16[27:0];
        dec_big  = |dec_x[27:26];
        dec_idx  = dec_x[25:20];
        dec_frac = dec_x[19:0];
        tab_hi   = EXP_TAB[dec_idx];
        // Last segment interpolates toward zero.
        tab_lo   = (dec_idx == 6'd63) ? 16'd0 : EXP_TAB[dec_idx + 6'd1];
        tab_diff = tab_hi - tab_lo;

        // Slope*frac >> 20 is the hi word of the 20-step multiply.
        factor   = r_tab_hi - {4'd0, mul_rsp.hi[11:0]};
        env_dec  = p16[30:15];

        // Chase fraction, clamped to 1.0 in Q8.24.
        chase_prod = p16[31:0];
        alpha      = (chase_prod > 32'h0100_0000) ? MUL_A_W'(25'h100_0000)
                                                  : chase_prod[MUL_A_W-1:0];
        env_ge     = (r_env >= r_sm);
        env_gap    = env_ge ? (r_env - r_sm) : (r_sm - r_env);

        step     = p16[39:24];
        sm_next  = r_dir ? (r_sm + step) : (r_sm - step);
        snap     = (r_env < cfg.snap_floor) && (sm_next < cfg.snap_floor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mreq.start <= 1'b0;
            r_out_valid  <= 1'b0;
            r_env        <= '0;
            r_sm         <= '0;
        end else begin
            r_mreq.start <= 1'b0;
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (evt_fire) begin
                        r_state <= ST_DONE;
                        case (t_cmd'(i_evt.cmd))
                            CMD_HIT: begin
                                if (i_evt.amount != '0) begin
                                    r_mreq.start <= 1'b1;
                                    r_mreq.a     <= MUL_A_W'(cfg.hit_gain);
                                    r_mreq.b     <= MUL_B_W'(i_evt.amount);
                                    r_mreq.len   <= MUL_LEN_SHORT;
                                    r_state      <= ST_HIT_MUL;
                                end
                            end
                            CMD_DEATH: r_env <= ONE_Q15;
                            CMD_TICK: begin
                                if (i_evt.dt != '0) begin
                                    r_dt         <= i_evt.dt;
                                    r_mreq.start <= 1'b1;
                                    r_mreq.a     <= MUL_A_W'(cfg.decay_rate);
                                    r_mreq.b     <= MUL_B_W'(i_evt.dt);
                                    r_mreq.len   <= MUL_LEN_SHORT;
                                    r_state      <= ST_DEC_X;
                                end
                            end
                            CMD_CLEAR: begin
                                r_env <= '0;
                                r_sm  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_HIT_MUL: begin
                    if (mul_rsp.done) begin
                        r_bump  <= hit_bump;
                        r_state <= ST_HIT_SUM;
                    end
                end
                ST_HIT_SUM: begin
                    r_env   <= hit_env;
                    r_state <= ST_DONE;
                end
                ST_DEC_X: begin
                    if (mul_rsp.done) begin
                        r_mreq.start <= 1'b1;
                        if (dec_big) begin
                            // Argument at or past 4.0: factor is zero.
                            r_env      <= '0;
                            r_mreq.a   <= MUL_A_W'(cfg.chase_rate);
                            r_mreq.b   <= MUL_B_W'(r_dt);
                            r_mreq.len <= MUL_LEN_SHORT;
                            r_state    <= ST_CHASE_A;
                        end else begin
                            r_tab_hi   <= tab_hi;
                            r_mreq.a   <= MUL_A_W'(tab_diff);
                            r_mreq.b   <= dec_frac;
                            r_mreq.len <= MUL_LEN_LONG;
                            r_state    <= ST_DEC_F;
                        end
                    end
                end
                ST_DEC_F: begin
                    if (mul_rsp.done) begin
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= MUL_A_W'(factor);
                        r_mreq.b     <= MUL_B_W'(r_env);
                        r_mreq.len   <= MUL_LEN_SHORT;
                        r_state      <= ST_DEC_E;
                    end
                end
                ST_DEC_E: begin
                    if (mul_rsp.done) begin
                        r_env        <= env_dec;
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= MUL_A_W'(cfg.chase_rate);
                        r_mreq.b     <= MUL_B_W'(r_dt);
                        r_mreq.len   <= MUL_LEN_SHORT;
                        r_state      <= ST_CHASE_A;
                    end
                end
                ST_CHASE_A: begin
                    if (mul_rsp.done) begin
                        r_dir        <= env_ge;
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= alpha;
                        r_mreq.b     <= MUL_B_W'(env_gap);
                        r_mreq.len   <= MUL_LEN_SHORT;
                        r_state      <= ST_CHASE_S;
                    end
                end
                ST_CHASE_S: begin
                    if (mul_rsp.done) begin
                        if (snap) begin
                            r_env <= '0;
                            r_sm  <= '0;
                        end else begin
                            r_sm <= sm_next;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold here until the result register can take the beat.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_level     <= r_sm;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_evt.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.level = r_level;

endmodule

// ===== hw/rtl/hes_checker.sv =====
// ----------------------------------------------------------------------------
// hes_checker: port-level checks for the hit envelope smoother
// Watches the event and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module hes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_level
);
    import hes_pkg::*;

    // A stalled result beat holds its level.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_level)))
        else $error("result beat dropped or changed under stall");

    // The level never exceeds 1.0.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_level <= ONE_Q15))
        else $error("level above 1.0");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One event at a time: an accepted event blocks the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("event accepted while another is in flight");

endmodule

bind hit_envelope_smoother hes_checker u_hes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_evt.valid),
    .i_in_ready (i_evt.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_level    (o_res.level)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hit envelope smoother
// Drives event beats through the valid/ready input channel and tracks the
// envelope and smoothed stages in a bit-exact software copy. Every result
// beat is compared against that copy. The run steps through several register
// settings, the extremes among them, with random idling on both channels and
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import hes_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The
    // slowest legal stretch is the output hold-off plus one full tick.
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 50;
    localparam int DRAIN_CYCLES    = 150;
    localparam int IDLE_PCT        = 25;
    localparam int PRINT_CAP       = 40;
    localparam logic [31:0] ALPHA_ONE = 32'h0100_0000;   // 1.0 in Q8.24

    // Raw register write data, one 16-bit word per register index.
    typedef struct packed {
        logic [15:0] min_bump;
        logic [15:0] hit_gain;
        logic [15:0] decay_rate;
        logic [15:0] chase_rate;
        logic [15:0] snap_floor;
    } reg_image;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] amount;
        logic [15:0] dt;
    } event_beat;

    // ------------------------------------------------------------------------
    // Envelope tracker: holds its own copy of the registers and both stages,
    // and the queue of levels still owed by the block.
    // ------------------------------------------------------------------------
    class envelope_tracker;
        t_cfg        regs;
        logic [15:0] envelope_lvl;
        logic [15:0] smooth_lvl;
        logic [15:0] level_due[$];
        int          mismatches;
        int          levels_seen;
        int          cmd_count[4];

        function new();
            regs.min_bump   = RST_MIN_BUMP;
            regs.hit_gain   = RST_HIT_GAIN;
            regs.decay_rate = RST_DECAY_RATE;
            regs.chase_rate = RST_CHASE_RATE;
            regs.snap_floor = RST_SNAP_FLOOR;
            envelope_lvl = '0;
            smooth_lvl   = '0;
            mismatches   = 0;
            levels_seen  = 0;
            foreach (cmd_count[k]) cmd_count[k] = 0;
        endfunction

        // Write data wider than a register loses its upper bits; indexes past
        // the last register change nothing.
        function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MIN_BUMP:   regs.min_bump   = data;
                CFG_HIT_GAIN:   regs.hit_gain   = data;
                CFG_DECAY_RATE: regs.decay_rate = data[DECAY_W-1:0];
                CFG_CHASE_RATE: regs.chase_rate = data;
                CFG_SNAP_FLOOR: regs.snap_floor = data;
                default: ;
            endcase
        endfunction

        // exp(-x) for x in Q4.24: table lookup with linear interpolation, the
        // last segment running down to zero, and zero from 4.0 up.
        function logic [15:0] decay_factor(logic [31:0] x);
            logic [5:0]  seg;
            logic [19:0] frac;
            logic [15:0] hi;
            logic [15:0] lo;
            logic [35:0] drop;
            if ((x >> 26) != 0) return '0;
            seg  = x[25:20];
            frac = x[19:0];
            hi   = EXP_TAB[seg];
            lo   = (seg == 6'd63) ? 16'd0 : EXP_TAB[seg + 6'd1];
            drop = 36'(hi - lo) * 36'(frac);
            return hi - 16'(drop >> 20);
        endfunction

        // Advance both stages for one accepted event and queue its level.
        function void advance_envelope(t_cmd cmd, logic [15:0] amount, logic [15:0] dt);
            logic [31:0] bump;
            logic [31:0] sum;
            logic [31:0] arg;
            logic [31:0] rate;
            logic [24:0] alpha;
            logic [15:0] gap;
            logic [15:0] step;
            cmd_count[cmd]++;
            case (cmd)
                CMD_HIT: begin
                    if (amount != 16'd0) begin
                        bump = (32'(amount) * 32'(regs.hit_gain)) >> 9;
                        if (bump < 32'(regs.min_bump)) bump = 32'(regs.min_bump);
                        sum = 32'(envelope_lvl) + bump;
                        envelope_lvl = (sum > 32'(ONE_Q15)) ? ONE_Q15 : sum[15:0];
                    end
                end
                CMD_DEATH: begin
                    envelope_lvl = ONE_Q15;
                end
                CMD_TICK: begin
                    if (dt != 16'd0) begin
                        arg = 32'(regs.decay_rate) * 32'(dt);
                        envelope_lvl = 16'((48'(envelope_lvl) * 48'(decay_factor(arg))) >> 15);
                        rate  = 32'(regs.chase_rate) * 32'(dt);
                        alpha = (rate > ALPHA_ONE) ? ALPHA_ONE[24:0] : rate[24:0];
                        if (envelope_lvl >= smooth_lvl) begin
                            gap  = envelope_lvl - smooth_lvl;
                            step = 16'((48'(gap) * 48'(alpha)) >> 24);
                            smooth_lvl = smooth_lvl + step;
                        end else begin
                            gap  = smooth_lvl - envelope_lvl;
                            step = 16'((48'(gap) * 48'(alpha)) >> 24);
                            smooth_lvl = smooth_lvl - step;
                        end
                        if (envelope_lvl < regs.snap_floor && smooth_lvl < regs.snap_floor) begin
                            envelope_lvl = '0;
                            smooth_lvl   = '0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    envelope_lvl = '0;
                    smooth_lvl   = '0;
                end
                default: ;
            endcase
            level_due.push_back(smooth_lvl);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_level(logic [15:0] level);
            logic [15:0] want;
            levels_seen++;
            if (level_due.size() == 0) begin
                report($sformatf("level %0d arrived with no event outstanding", level));
            end else begin
                want = level_due.pop_front();
                if (level !== want) report($sformatf("level %0d, expected %0d", level, want));
            end
        endtask

        function int pending();
            return level_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and channels
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hes_evt_if evt_ch ();
    hes_res_if res_ch ();

    envelope_tracker tracker = new();

    int beats_in      = 0;
    int beats_out     = 0;
    int settings_used = 1;   // reset values count as the first setting
    bit calm          = 1'b0;
    bit hold_due      = 1'b0;
    int held_cycles   = 0;

    hit_envelope_smoother dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one event beat and hold it until the block takes it. Valid stays
    // high on return so back-to-back beats need no extra edge; random idle
    // cycles drop it in between.
    task automatic send_event(input t_cmd cmd, input logic [15:0] amount, input logic [15:0] dt);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                evt_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        evt_ch.valid  <= 1'b1;
        evt_ch.cmd    <= cmd;
        evt_ch.amount <= amount;
        evt_ch.dt     <= dt;
        do @(posedge i_clk); while (evt_ch.ready !== 1'b1);
        beats_in++;
        tracker.advance_envelope(cmd, amount, dt);
    endtask

    // Drop valid and wait until every owed level is back, so the block is
    // idle before the registers change.
    task automatic drain_levels();
        evt_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_cfg(idx, data);
    endtask

    // Write all five registers, then poke every unused index with junk that
    // must not land anywhere.
    task automatic program_config(input reg_image img);
        logic [CFG_IDX_W-1:0] stray;
        write_reg(CFG_MIN_BUMP,   img.min_bump);
        write_reg(CFG_HIT_GAIN,   img.hit_gain);
        write_reg(CFG_DECAY_RATE, img.decay_rate);
        write_reg(CFG_CHASE_RATE, img.chase_rate);
        write_reg(CFG_SNAP_FLOOR, img.snap_floor);
        for (int k = 1; int'(CFG_SNAP_FLOOR) + k < (1 << CFG_IDX_W); k++) begin
            stray = CFG_IDX_W'(int'(CFG_SNAP_FLOOR) + k);
            write_reg(stray, 16'($urandom_range(0, 65535)));
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly in-range settings; now and then an oversized bump or snap floor. The
    // decay write carries random upper bits that the register must drop.
    function automatic reg_image random_config();
        reg_image img;
        img.min_bump   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(32769, 65535))
                                                     : 16'($urandom_range(0, 32768));
        img.hit_gain   = 16'($urandom_range(0, 65535));
        img.decay_rate = 16'($urandom_range(0, 65535));
        img.chase_rate = 16'($urandom_range(0, 65535));
        img.snap_floor = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 1024));
        return img;
    endfunction

    // Mostly ticks and hits as a game would send them, with short frame-like
    // ticks and modest damage, plus full-range values and zero fields.
    function automatic event_beat random_beat();
        event_beat beat;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      beat.cmd = CMD_HIT;
        else if (pick < 80) beat.cmd = CMD_TICK;
        else if (pick < 92) beat.cmd = CMD_DEATH;
        else                beat.cmd = CMD_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 8)       beat.amount = '0;
        else if (pick < 50) beat.amount = 16'($urandom_range(1, 1024));
        else                beat.amount = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 8)       beat.dt = '0;
        else if (pick < 58) beat.dt = 16'($urandom_range(1, 2200));
        else                beat.dt = 16'($urandom_range(0, 65535));
        return beat;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        event_beat beat;
        reg_image  img;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MIN_BUMP;
        i_cfg_data    <= '0;
        evt_ch.valid  <= 1'b0;
        evt_ch.cmd    <= CMD_HIT;
        evt_ch.amount <= '0;
        evt_ch.dt     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a tick from rest, zero hit ignored, minimum bump, saturation, zero
        // tick, a frame tick, a long tick that makes the chase fraction 1, death, clear.
        send_event(CMD_TICK,  16'd0,      16'd1);
        send_event(CMD_HIT,   16'd0,      16'd0);
        send_event(CMD_HIT,   16'd1,      16'd0);
        send_event(CMD_HIT,   16'hFFFF,   16'd0);
        send_event(CMD_TICK,  16'd0,      16'd0);
        send_event(CMD_TICK,  16'd0,      16'd1092);
        send_event(CMD_TICK,  16'd0,      16'hFFFF);
        send_event(CMD_DEATH, 16'd0,      16'd0);
        send_event(CMD_TICK,  16'd0,      16'h8000);
        send_event(CMD_CLEAR, 16'hFFFF,   16'hFFFF);
        send_event(CMD_DEATH, 16'hFFFF,   16'hFFFF);

        // Fastest decay, no snapping: land in the last table segment, just
        // under 4.0, and just past it where the factor is zero.
        drain_levels();
        img = '{min_bump: 16'd32768, hit_gain: 16'hFFFF, decay_rate: 16'hFFFF,
                chase_rate: 16'hFFFF, snap_floor: 16'd0};
        program_config(img);
        send_event(CMD_TICK,  16'd0,      16'd16200);
        send_event(CMD_TICK,  16'd0,      16'd16388);
        send_event(CMD_HIT,   16'hFFFF,   16'd0);
        send_event(CMD_TICK,  16'd0,      16'd16389);
        send_event(CMD_HIT,   16'd1,      16'd0);

        // Oversized bump with zero gain, no decay, no chase, and a snap floor
        // above full scale so every tick snaps.
        drain_levels();
        img = '{min_bump: 16'hFFFF, hit_gain: 16'd0, decay_rate: 16'd0,
                chase_rate: 16'd0, snap_floor: 16'hFFFF};
        program_config(img);
        send_event(CMD_HIT,   16'd5,      16'd0);
        send_event(CMD_TICK,  16'd0,      16'hFFFF);
        send_event(CMD_DEATH, 16'd0,      16'd0);
        send_event(CMD_TICK,  16'd0,      16'd1);

        // Everything zero: hits add nothing, ticks change nothing.
        drain_levels();
        program_config('0);
        send_event(CMD_HIT,   16'h0100,   16'd0);
        send_event(CMD_DEATH, 16'd0,      16'd0);
        send_event(CMD_TICK,  16'd0,      16'd100);
        send_event(CMD_CLEAR, 16'd0,      16'd0);

        // Random phases. One runs with no idling on either side, one holds
        // the output off long enough to fill the block, the last one goes
        // back to the reset settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_levels();
            if (ph == RANDOM_PHASES - 1) begin
                img = '{min_bump: RST_MIN_BUMP, hit_gain: RST_HIT_GAIN,
                        decay_rate: 16'(RST_DECAY_RATE), chase_rate: RST_CHASE_RATE,
                        snap_floor: RST_SNAP_FLOOR};
            end else begin
                img = random_config();
            end
            program_config(img);
            calm = (ph == 1);
            if (ph == 3) hold_due = 1'b1;
            repeat (BEATS_PER_PHASE) begin
                beat = random_beat();
                send_event(beat.cmd, beat.amount, beat.dt);
            end
        end
        calm = 1'b0;

        // Wait out every owed level, then a margin for anything stray.
        drain_levels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d levels never arrived", tracker.pending()));

        $display("Ran %0d events (%0d hits, %0d deaths, %0d ticks, %0d clears) over %0d settings.",
                 beats_in, tracker.cmd_count[CMD_HIT], tracker.cmd_count[CMD_DEATH],
                 tracker.cmd_count[CMD_TICK], tracker.cmd_count[CMD_CLEAR], settings_used);
        $display("Checked %0d levels, output held off %0d cycles once, %0d mismatches.",
                 tracker.levels_seen, held_cycles, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: check every accepted beat, idle ready at random, and run
    // the one long hold-off when asked.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                beats_out++;
                tracker.check_level(res_ch.level);
            end
            if (hold_due) begin
                hold_due    = 1'b0;
                hold_left   = HOLD_CYCLES;
                held_cycles = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        int last_in;
        int last_out;
        quiet    = 0;
        last_in  = 0;
        last_out = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (beats_in != last_in || beats_out != last_out) begin
                quiet    = 0;
                last_in  = beats_in;
                last_out = beats_out;
            end else begin
                quiet++;
            end
        end
        $display("Timed out after %0d idle cycles with %0d levels outstanding.",
                 STALL_LIMIT, tracker.pending());
        $display("FAIL");
        $finish;
    end

endmodule
